[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle, gated by the active-low reset
`define SWV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a result in the next cycle
`define SWV_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[hw/rtl/swv_pkg.sv]
// Shared widths, codes, beat types and helpers of the square wave sequencer
package swv_pkg;

    localparam int POT_W     = 24;
    localparam int AMP_W     = POT_W - 1;
    localparam int CUR_W     = 32;
    localparam int DIF_W     = CUR_W + 1;
    localparam int CNT_W     = 16;
    localparam int PHASE_W   = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PINC  = 2'd3;

    // Half codes, used both for the phase state and for half_state
    localparam logic [1:0] HALF_NONE = 2'd0;
    localparam logic [1:0] HALF_HIGH = 2'd1;
    localparam logic [1:0] HALF_LOW  = 2'd2;

    localparam logic [POT_W-1:0] POT_MAX = {1'b0, {(POT_W-1){1'b1}}};
    localparam logic [POT_W-1:0] POT_MIN = {1'b1, {(POT_W-1){1'b0}}};

    typedef struct packed {
        logic [POT_W-1:0]   start_potential;
        logic [POT_W-1:0]   step_potential;
        logic [AMP_W-1:0]   amplitude;
        logic [PHASE_W-1:0] phase_increment;
    } t_cfg;

    typedef struct packed {
        logic             restart;
        logic [CUR_W-1:0] cell_current;
    } t_in_beat;

    typedef struct packed {
        logic [POT_W-1:0] drive_potential;
        logic [1:0]       half_state;
        logic             record_valid;
        logic [DIF_W-1:0] diff_current;
        logic [CUR_W-1:0] forward_current;
        logic [POT_W-1:0] record_potential;
        logic [CNT_W-1:0] period_index;
        logic             peak_found;
    } t_out_beat;

    // Waveform event handed from the waveform unit to the record unit
    typedef struct packed {
        logic [1:0]       half_state;
        logic [POT_W-1:0] base_level;
    } t_wave_evt;

    // Clamp a one-bit-wider sum to the signed potential range
    function automatic logic [POT_W-1:0] sat_pot(input logic [POT_W:0] v);
        logic [POT_W-1:0] res;
        if (v[POT_W] != v[POT_W-1]) begin
            res = v[POT_W] ? POT_MIN : POT_MAX;
        end else begin
            res = v[POT_W-1:0];
        end
        return res;
    endfunction

endpackage

[hw/rtl/square_wave_voltammetry_sequencer.sv]
// An accepted input beat passes the input register, then the output register.
// Throughput: one beat per cycle unless the output stalls; the tick-to-tick state update
// is one pass of adds and compares between the input and output registers.
// Input and output registers are decoupled, so a beat is taken while a result waits.
// Reset (synchronous, active low) clears config, sequencer state and both valids.
module square_wave_voltammetry_sequencer
    import swv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_beat             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_beat            o_out_data
);

    t_cfg      cfg;
    t_in_beat  r_in;
    logic      r_in_vld;
    t_out_beat r_out, n_out;
    logic      r_out_vld;
    logic      adv;
    logic      in_take;
    t_wave_evt evt;

    // Move a beat to the output register when it is empty or being drained
    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    swv_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    swv_wave u_wave (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_restart (r_in.restart),
        .i_cfg     (cfg),
        .o_drive   (n_out.drive_potential),
        .o_evt     (evt)
    );

    swv_rec u_rec (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_evt          (evt),
        .i_cur          (r_in.cell_current),
        .o_record_valid (n_out.record_valid),
        .o_diff         (n_out.diff_current),
        .o_forward      (n_out.forward_current),
        .o_rec_pot      (n_out.record_potential),
        .o_index        (n_out.period_index),
        .o_peak         (n_out.peak_found)
    );

    assign n_out.half_state = evt.half_state;

    // Input register: load on accept, drop once advanced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/swv_cfg.sv]
// Configuration register file of the square wave sequencer
module swv_cfg
    import swv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Decode the index and load the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START: r_cfg.start_potential <= i_cfg_data[POT_W-1:0];
                CFG_STEP:  r_cfg.step_potential  <= i_cfg_data[POT_W-1:0];
                CFG_AMP:   r_cfg.amplitude       <= i_cfg_data[AMP_W-1:0];
                CFG_PINC:  r_cfg.phase_increment <= i_cfg_data[PHASE_W-1:0];
                default:   r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/swv_wave.sv]
// Phase accumulator, staircase base level and drive potential
module swv_wave
    import swv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_restart,
    input  t_cfg             i_cfg,
    output logic [POT_W-1:0] o_drive,
    output t_wave_evt        o_evt
);

    logic [POT_W-1:0]   r_base, n_base;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [1:0]         r_cur_half, n_cur_half;
    logic [1:0]         r_next_half, n_next_half;

    logic [POT_W-1:0] base_st;
    logic [POT_W:0]   base_sum;
    logic [POT_W:0]   drive_sum;
    logic [POT_W:0]   amp_ext;
    logic [1:0]       hs;

    always_comb begin
        // Step the staircase on the first tick of a new period
        base_sum = {r_base[POT_W-1], r_base}
                 + {i_cfg.step_potential[POT_W-1], i_cfg.step_potential};
        base_st  = (r_cur_half == HALF_LOW && r_next_half == HALF_HIGH)
                 ? sat_pot(base_sum) : r_base;

        n_cur_half  = r_phase[PHASE_W-1] ? HALF_LOW : HALF_HIGH;
        n_phase     = r_phase + i_cfg.phase_increment;
        n_next_half = n_phase[PHASE_W-1] ? HALF_LOW : HALF_HIGH;

        // Add amplitude in the high half, subtract it in the low half
        amp_ext   = {2'b00, i_cfg.amplitude};
        drive_sum = (n_cur_half == HALF_HIGH)
                  ? {base_st[POT_W-1], base_st} + amp_ext
                  : {base_st[POT_W-1], base_st} - amp_ext;

        if (n_cur_half == HALF_HIGH && n_next_half == HALF_LOW) begin
            hs = HALF_HIGH;
        end else if (n_cur_half == HALF_LOW && n_next_half == HALF_HIGH) begin
            hs = HALF_LOW;
        end else begin
            hs = HALF_NONE;
        end

        n_base  = base_st;
        o_drive = sat_pot(drive_sum);
        o_evt.half_state = hs;
        o_evt.base_level = base_st;

        // Restart: reload the base, clear the phase, hold the drive at base
        if (i_restart) begin
            n_base      = i_cfg.start_potential;
            n_phase     = '0;
            n_cur_half  = HALF_NONE;
            n_next_half = HALF_HIGH;
            o_drive     = i_cfg.start_potential;
            o_evt.half_state = HALF_NONE;
            o_evt.base_level = i_cfg.start_potential;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_phase     <= '0;
            r_cur_half  <= HALF_NONE;
            r_next_half <= HALF_NONE;
        end else if (i_adv) begin
            r_base      <= n_base;
            r_phase     <= n_phase;
            r_cur_half  <= n_cur_half;
            r_next_half <= n_next_half;
        end
    end

endmodule

[hw/rtl/swv_rec.sv]
// Forward current hold, period records and peak detector
module swv_rec
    import swv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  t_wave_evt        i_evt,
    input  logic [CUR_W-1:0] i_cur,
    output logic             o_record_valid,
    output logic [DIF_W-1:0] o_diff,
    output logic [CUR_W-1:0] o_forward,
    output logic [POT_W-1:0] o_rec_pot,
    output logic [CNT_W-1:0] o_index,
    output logic             o_peak
);

    logic [CUR_W-1:0] r_held;
    logic [DIF_W-1:0] r_hist_new;
    logic [DIF_W-1:0] r_hist_mid;
    logic [CNT_W-1:0] r_count, n_count;
    logic [DIF_W-1:0] r_best;
    logic             r_no_peak;

    logic             is_rec;
    logic             is_fwd;
    logic [DIF_W-1:0] dif;
    logic             peak;

    always_comb begin
        is_fwd = (i_evt.half_state == HALF_HIGH);
        is_rec = (i_evt.half_state == HALF_LOW);
        dif    = {r_held[CUR_W-1], r_held} - {i_cur[CUR_W-1], i_cur};

        // Saturate the period counter at its top value
        n_count = (r_count == {CNT_W{1'b1}}) ? r_count : r_count + 1'b1;

        // Middle difference must beat both neighbors and the best peak so far
        peak = is_rec && (n_count > CNT_W'(2))
            && ($signed(r_hist_new) > $signed(dif))
            && ($signed(r_hist_new) > $signed(r_hist_mid))
            && (r_no_peak || ($signed(r_best) < $signed(r_hist_new)));

        o_record_valid = is_rec;
        o_diff    = is_rec ? dif : '0;
        o_forward = is_rec ? r_held : '0;
        o_rec_pot = is_rec ? i_evt.base_level : '0;
        o_index   = is_rec ? r_count : '0;
        o_peak    = peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_hist_new <= '0;
            r_hist_mid <= '0;
            r_count    <= '0;
            r_best     <= '0;
            r_no_peak  <= 1'b1;
        end else if (i_adv) begin
            if (is_fwd) begin
                r_held <= i_cur;
            end
            if (is_rec) begin
                r_count    <= n_count;
                r_hist_mid <= r_hist_new;
                r_hist_new <= dif;
            end
            if (peak) begin
                r_best    <= r_hist_new;
                r_no_peak <= 1'b0;
            end
        end
    end

endmodule

[hw/rtl/swv_chk.sv]
// Port-level checker for the square wave sequencer, bound to the top level
`include "assert_macros.svh"

module swv_chk
    import swv_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_beat            o_out_data
);

    // A stalled output beat stays valid
    `SWV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "output beat dropped while stalled")

    // Input side stalls only under output backpressure
    `SWV_ASSERT(a_stall_src, i_clk, i_rst_n, !o_in_stall || (o_out_valid && i_out_stall), "input stalled without output backpressure")

    // A period record comes exactly at the end of a low half
    `SWV_ASSERT(a_rec_half, i_clk, i_rst_n, !o_out_valid || (o_out_data.record_valid == (o_out_data.half_state == HALF_LOW)), "record flag and half state disagree")

    // Peak flag, period index and difference stay zero without a record
    `SWV_ASSERT(a_rec_zero, i_clk, i_rst_n, !o_out_valid || o_out_data.record_valid || (!o_out_data.peak_found && o_out_data.period_index == '0 && o_out_data.diff_current == '0), "record fields set without a record")

endmodule

bind square_wave_voltammetry_sequencer swv_chk u_swv_chk (.*);

[tb/square_wave_voltammetry_sequencer_tb.sv]
// Self-checking testbench for the square wave voltammetry sequencer
`timescale 1ns / 100ps

module square_wave_voltammetry_sequencer_tb;
    import swv_pkg::*;

    localparam int CNT_MAX     = (1 << CNT_W) - 1;
    localparam int PHASE_BEATS = 130;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_START;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_beat             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_beat            o_out_data;

    square_wave_voltammetry_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // Register copies as last written
    logic [POT_W-1:0]   cfg_start = '0;
    logic [POT_W-1:0]   cfg_step = '0;
    logic [AMP_W-1:0]   cfg_amp = '0;
    logic [PHASE_W-1:0] cfg_pinc = '0;

    // Waveform and record state of the predictor
    longint       wave_base = 0;
    logic [31:0]  wave_phase = '0;
    logic [1:0]   wave_cur = HALF_NONE;
    logic [1:0]   wave_next = HALF_NONE;
    longint       wave_fwd = 0;
    longint       diff_hist [3] = '{0, 0, 0};
    int           wave_count = 0;
    longint       best_peak = 0;
    logic         no_peak_yet = 1'b1;

    t_in_beat  ticks_to_send [$];
    t_out_beat ticks_in_flight [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    logic hold_used = 1'b0;
    int beats_sent = 0;
    int beats_checked = 0;
    int records_seen = 0;
    int peaks_seen = 0;
    int settings_used = 0;
    int errors = 0;

    function automatic longint clamp_pot(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (POT_W - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic logic [1:0] half_at(input logic [31:0] ph);
        return ph[31] ? HALF_LOW : HALF_HIGH;
    endfunction

    // Advance the waveform by one tick and build the output beat it causes
    function automatic t_out_beat step_waveform(input t_in_beat b);
        t_out_beat o;
        longint cur;
        longint amp;
        longint drv;
        longint dif;
        longint mid;
        o = '0;
        cur = longint'($signed(b.cell_current));
        if (b.restart) begin
            wave_base = longint'($signed(cfg_start));
            o.drive_potential = cfg_start;
            wave_phase = '0;
            wave_cur = HALF_NONE;
            wave_next = HALF_HIGH;
        end else begin
            amp = longint'(cfg_amp);
            if (wave_cur == HALF_LOW && wave_next == HALF_HIGH) begin
                wave_base = clamp_pot(wave_base + longint'($signed(cfg_step)));
            end
            wave_cur = half_at(wave_phase);
            drv = clamp_pot((wave_cur == HALF_HIGH) ? wave_base + amp : wave_base - amp);
            o.drive_potential = drv[POT_W-1:0];
            wave_phase = wave_phase + cfg_pinc;
            wave_next = half_at(wave_phase);
            if (wave_cur == HALF_HIGH && wave_next == HALF_LOW) begin
                // hold the forward current at the end of the high half
                o.half_state = HALF_HIGH;
                wave_fwd = cur;
            end else if (wave_cur == HALF_LOW && wave_next == HALF_HIGH) begin
                // close the period and run the peak search
                o.half_state = HALF_LOW;
                o.record_valid = 1'b1;
                dif = wave_fwd - cur;
                o.diff_current = dif[DIF_W-1:0];
                o.forward_current = wave_fwd[CUR_W-1:0];
                o.record_potential = wave_base[POT_W-1:0];
                o.period_index = wave_count[CNT_W-1:0];
                if (wave_count < CNT_MAX) wave_count++;
                diff_hist[2] = diff_hist[1];
                diff_hist[1] = diff_hist[0];
                diff_hist[0] = dif;
                mid = diff_hist[1];
                if (wave_count > 2 && mid > diff_hist[0] && mid > diff_hist[2] &&
                    (no_peak_yet || best_peak < mid)) begin
                    no_peak_yet = 1'b0;
                    best_peak = mid;
                    o.peak_found = 1'b1;
                    peaks_seen++;
                end
                records_seen++;
            end
        end
        return o;
    endfunction

    // Pick a cell current; the spread widens phase by phase so new peaks keep appearing
    function automatic logic [31:0] pick_current(input int ph, input logic [31:0] prev);
        int r;
        int span;
        r = $urandom_range(9);
        span = 100 << (3 * ph);
        if (ph >= 6 && r == 0) return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
        if (ph >= 6 && r == 1) return $urandom;
        if (r == 2) return prev;
        return 32'($urandom_range(span) - span / 2);
    endfunction

    task automatic add_tick(input logic rs, input logic [31:0] cur);
        t_in_beat b;
        b.restart = rs;
        b.cell_current = cur;
        ticks_to_send.push_back(b);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_START: cfg_start = val[POT_W-1:0];
            CFG_STEP:  cfg_step = val[POT_W-1:0];
            CFG_AMP:   cfg_amp = val[AMP_W-1:0];
            default:   cfg_pinc = val[PHASE_W-1:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_levels(input logic [POT_W-1:0] st, input logic [POT_W-1:0] sp,
                              input logic [AMP_W-1:0] am, input logic [31:0] pi);
        write_reg(CFG_START, {{(CFG_W-POT_W){st[POT_W-1]}}, st});
        write_reg(CFG_STEP, {{(CFG_W-POT_W){sp[POT_W-1]}}, sp});
        write_reg(CFG_AMP, {{(CFG_W-AMP_W){1'b0}}, am});
        write_reg(CFG_PINC, pi);
        settings_used++;
    endtask

    // Wait until every tick went out and every beat came back
    task automatic wait_drained();
        while (ticks_to_send.size() != 0 || i_in_valid || ticks_in_flight.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Offer ticks from the queue, hold a stalled beat, predict on acceptance
    always @(posedge i_clk) begin : drive_ticks
        logic holding;
        holding = i_in_valid && o_in_stall;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                ticks_in_flight.push_back(step_waveform(i_in_data));
                beats_sent++;
            end
            if (!holding) begin
                if (ticks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_data <= ticks_to_send.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the output at random or through a long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Hold off the output once for a long stretch so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_used && beats_checked >= 300) begin
            hold_left <= 250;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Compare each accepted output beat with the oldest prediction
    always @(posedge i_clk) begin : check_ticks
        t_out_beat want;
        string bad;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (ticks_in_flight.size() == 0) begin
                errors++;
                if (errors <= 10) $display("output beat with nothing outstanding: %p", o_out_data);
            end else begin
                want = ticks_in_flight.pop_front();
                bad = "";
                if (want.drive_potential !== o_out_data.drive_potential)
                    bad = {bad, " drive_potential"};
                if (want.half_state !== o_out_data.half_state) bad = {bad, " half_state"};
                if (want.record_valid !== o_out_data.record_valid) bad = {bad, " record_valid"};
                if (want.diff_current !== o_out_data.diff_current) bad = {bad, " diff_current"};
                if (want.forward_current !== o_out_data.forward_current)
                    bad = {bad, " forward_current"};
                if (want.record_potential !== o_out_data.record_potential)
                    bad = {bad, " record_potential"};
                if (want.period_index !== o_out_data.period_index) bad = {bad, " period_index"};
                if (want.peak_found !== o_out_data.peak_found) bad = {bad, " peak_found"};
                if (bad != "") begin
                    errors++;
                    if (errors <= 10) begin
                        $display("beat %0d wrong in%s", beats_checked, bad);
                        $display("  expected %p", want);
                        $display("  actual   %p", o_out_data);
                    end
                end
            end
            beats_checked++;
        end
    end

    // Stimulus: directed ticks, then random phases under several settings
    initial begin : stimulus
        logic [31:0] last_cur;
        logic [31:0] pinc;
        int span;
        last_cur = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 9;
                recv_idle_pct = 69;
            end else if (ph < 6) begin
                send_idle_pct = 69;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0: set_levels(24'd0, 24'd100, 23'd50, 32'h4000_0000);
                1: set_levels(POT_MAX, POT_MAX, {AMP_W{1'b1}}, 32'h8000_0000);
                2: set_levels(POT_MIN, POT_MIN, {AMP_W{1'b1}}, 32'hc000_0000);
                3: set_levels(24'd0, 24'd0, 23'd0, 32'h0000_0000);
                4: set_levels(24'($urandom), 24'($urandom), 23'($urandom), 32'hffff_ffff);
                default: begin
                    pinc = $urandom_range(32'hffff_ffff, 32'h1000_0000);
                    span = $urandom_range(1) ? 4000 : 32'h00ff_ffff;
                    set_levels(24'($urandom_range(4000) - 2000), 24'($urandom_range(span) - span / 2),
                               23'($urandom), pinc);
                end
            endcase

            if (ph == 0) begin
                // ticks before any restart run from the reset state
                add_tick(1'b0, 32'd3);
                add_tick(1'b0, 32'hffff_ffff);
                add_tick(1'b0, 32'd0);
                add_tick(1'b1, 32'd0);
                // periods of four ticks: forward at the second, reverse at the fourth;
                // current extremes first, then a plain local peak
                add_tick(1'b0, 32'd0); add_tick(1'b0, 32'h7fff_ffff);
                add_tick(1'b0, 32'd0); add_tick(1'b0, 32'h8000_0000);
                add_tick(1'b0, 32'd0); add_tick(1'b0, 32'h8000_0000);
                add_tick(1'b0, 32'd0); add_tick(1'b0, 32'h7fff_ffff);
                add_tick(1'b0, 32'hffff_ffff); add_tick(1'b0, 32'd10);
                add_tick(1'b0, 32'd0); add_tick(1'b0, 32'd0);
                add_tick(1'b0, 32'd0); add_tick(1'b0, 32'd5);
                add_tick(1'b0, 32'hffff_ffff); add_tick(1'b0, 32'd0);
                add_tick(1'b0, 32'd0); add_tick(1'b0, 32'd10);
                add_tick(1'b0, 32'd0); add_tick(1'b0, 32'd0);
            end

            // mostly long sweeps, with an occasional restart
            for (int n = 0; n < PHASE_BEATS; n++) begin
                last_cur = pick_current(ph, last_cur);
                add_tick($urandom_range(39) == 0, last_cur);
            end
            wait_drained();
        end

        $display("%0d ticks sent and %0d checked over %0d register settings,",
                 beats_sent, beats_checked, settings_used);
        $display("%0d period records and %0d flagged peaks, with one long output hold",
                 records_seen, peaks_seen);
        if (errors == 0 && ticks_in_flight.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
